[design/rfd_pkg.sv]
// Shared types, constants and helpers of the remote frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 2);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CFG_W       = 12;
    localparam int IDX_CFG_W   = 3;

    localparam logic [10:0] OFFSET_RESET   = 11'd1024;
    localparam logic [10:0] ERR_LIM_RESET  = 11'd700;
    localparam logic [10:0] DEADBAND_RESET = 11'd10;
    localparam logic [11:0] JUMP_LIM_RESET = 12'd500;
    localparam logic [1:0]  SW_DOWN_RESET  = 2'd2;
    localparam logic [1:0]  SW_INVALID     = 2'd0;

    typedef enum logic [IDX_CFG_W-1:0] {
        REG_CHANNEL_OFFSET   = 3'd0,
        REG_ERROR_LIMIT      = 3'd1,
        REG_DEADBAND         = 3'd2,
        REG_JUMP_LIMIT       = 3'd3,
        REG_SWITCH_DOWN_CODE = 3'd4
    } reg_index_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [10:0] channel_offset;
        logic [10:0] error_limit;
        logic [10:0] deadband;
        logic [11:0] jump_limit;
        logic [1:0]  switch_down_code;
    } cfg_t;

    typedef struct packed {
        logic            err;
        logic [3:0][11:0] ch;
        logic [15:0]     aux;
        logic [3:0]      sw;
        logic [15:0]     mouse_x;
        logic [15:0]     mouse_y;
        logic [15:0]     mouse_z;
        logic [15:0]     buttons;
        logic [15:0]     keys;
    } decoded_t;

    function automatic logic [11:0] abs12(input logic [11:0] v);
        abs12 = v[11] ? (~v + 12'd1) : v;
    endfunction

    function automatic logic [12:0] abs13(input logic [12:0] v);
        abs13 = v[12] ? (~v + 13'd1) : v;
    endfunction

endpackage

`default_nettype wire

[design/rfd_collect.sv]
// Byte counter and frame store: gathers bytes until the line goes idle.
`timescale 1ns / 1ps
`default_nettype none

module rfd_collect (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          line_idle,
    output logic               frame_done,
    output rfd_pkg::frame_t    frame
);
    import rfd_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    frame_t           store_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (line_idle)
            begin
                count_next = '0;
            end
            else if (count_reg <= CNT_W'(FRAME_BYTES))
            begin
                // saturate one past a full frame so an overlong frame is dropped
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !line_idle && (count_reg < CNT_W'(FRAME_BYTES)))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign frame_done = accept && line_idle && (count_reg == CNT_W'(FRAME_BYTES));
    assign frame      = store_reg;

endmodule

`default_nettype wire

[design/rfd_decode.sv]
// Frame unpack, offset removal and range/switch check into the decode register.
`timescale 1ns / 1ps
`default_nettype none

module rfd_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          frame_done,
    input  wire rfd_pkg::frame_t frame,
    input  wire rfd_pkg::cfg_t cfg,
    input  wire logic          advance,
    output logic               stage_valid,
    output rfd_pkg::decoded_t  stage
);
    import rfd_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    decoded_t         dec_reg;
    decoded_t         dec_next;
    logic [3:0][10:0] raw;
    logic [3:0][11:0] ch;
    logic             range_err;
    logic             err;
    logic [1:0]       sw_l;
    logic [1:0]       sw_r;

    always_comb
    begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        sw_l   = frame[5][5:4];
        sw_r   = frame[5][7:6];

        range_err = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            ch[i] = {1'b0, raw[i]} - {1'b0, cfg.channel_offset};
            if (abs12(ch[i]) > {1'b0, cfg.error_limit})
            begin
                range_err = 1'b1;
            end
        end
        err = range_err || (sw_l == SW_INVALID) || (sw_r == SW_INVALID);

        dec_next.err     = err;
        dec_next.ch      = ch;
        dec_next.aux     = {frame[17], frame[16]} - {5'd0, cfg.channel_offset};
        dec_next.sw      = {sw_r, sw_l};
        dec_next.mouse_x = {frame[7], frame[6]};
        dec_next.mouse_y = {frame[9], frame[8]};
        dec_next.mouse_z = {frame[11], frame[10]};
        dec_next.buttons = {frame[13], frame[12]};
        dec_next.keys    = {frame[15], frame[14]};

        // zero the data and force both switches down on a bad frame
        if (err)
        begin
            dec_next.ch      = '0;
            dec_next.aux     = '0;
            dec_next.sw      = {cfg.switch_down_code, cfg.switch_down_code};
            dec_next.mouse_x = '0;
            dec_next.mouse_y = '0;
            dec_next.mouse_z = '0;
            dec_next.buttons = '0;
            dec_next.keys    = '0;
        end

        valid_next = frame_done || (valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            dec_reg <= dec_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = dec_reg;

endmodule

`default_nettype wire

[design/rfd_filter.sv]
// Deadband on channel two, stick jump filter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rfd_filter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            stage_valid,
    input  wire rfd_pkg::decoded_t stage,
    input  wire rfd_pkg::cfg_t   cfg,
    input  wire logic            out_ready,
    output logic                 advance,
    output logic                 out_valid,
    output rfd_pkg::decoded_t    result
);
    import rfd_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    decoded_t         out_reg;
    decoded_t         out_next;
    logic [3:0][11:0] last_reg;
    logic [3:0][11:0] last_next;
    logic [3:0][11:0] ch;
    logic [3:0][12:0] diff;

    always_comb
    begin
        advance = stage_valid && (!out_valid_reg || out_ready);

        ch = stage.ch;
        if (abs12(ch[2]) <= {1'b0, cfg.deadband})
        begin
            ch[2] = '0;
        end

        out_next  = stage;
        last_next = last_reg;
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = {last_reg[i][11], last_reg[i]} - {ch[i][11], ch[i]};
            // hold the last accepted value when the stick jumps too far
            if (abs13(diff[i]) > {1'b0, cfg.jump_limit})
            begin
                out_next.ch[i] = last_reg[i];
            end
            else
            begin
                out_next.ch[i] = ch[i];
                last_next[i]   = ch[i];
            end
        end

        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

[design/remote_frame_decoder.sv]
// Top level of the remote control frame decoder.
`timescale 1ns / 1ps
`default_nettype none

// Each request is either one received byte (line_idle low) or an end-of-frame
// marker (line_idle high). Bytes are stored until the marker; a frame of exactly
// 18 bytes then yields one result, any other length yields none. A request is
// taken every cycle as long as the two-deep result path (decode register, then
// result register) has room, so requests stream at one per cycle. The decode
// register takes the unpack, offset and range/switch check; the result register
// takes the channel-two deadband and the jump filter against the last accepted
// stick values. Configuration writes take effect at the next edge and belong in
// idle periods only.
module remote_frame_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        line_idle,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [11:0]               stick_0,
    output logic signed [11:0]               stick_1,
    output logic signed [11:0]               stick_2,
    output logic signed [11:0]               stick_3,
    output logic signed [15:0]               aux_channel,
    output logic [3:0]                       switches,
    output logic signed [15:0]               mouse_x,
    output logic signed [15:0]               mouse_y,
    output logic signed [15:0]               mouse_z,
    output logic [15:0]                      mouse_buttons,
    output logic [15:0]                      key_bits,
    output logic                             data_error,
    input  wire logic                        cfg_we,
    input  wire logic [rfd_pkg::IDX_CFG_W-1:0] cfg_index,
    input  wire logic [rfd_pkg::CFG_W-1:0]   cfg_wdata
);
    import rfd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     accept;
    logic     frame_done;
    frame_t   frame;
    logic     stage_valid;
    decoded_t stage;
    logic     advance;
    decoded_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_OFFSET:   cfg_next.channel_offset   = cfg_wdata[10:0];
                REG_ERROR_LIMIT:      cfg_next.error_limit      = cfg_wdata[10:0];
                REG_DEADBAND:         cfg_next.deadband         = cfg_wdata[10:0];
                REG_JUMP_LIMIT:       cfg_next.jump_limit       = cfg_wdata[11:0];
                REG_SWITCH_DOWN_CODE: cfg_next.switch_down_code = cfg_wdata[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_offset   <= OFFSET_RESET;
            cfg_reg.error_limit      <= ERR_LIM_RESET;
            cfg_reg.deadband         <= DEADBAND_RESET;
            cfg_reg.jump_limit       <= JUMP_LIM_RESET;
            cfg_reg.switch_down_code <= SW_DOWN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !stage_valid || advance;
    assign accept   = in_valid && in_ready;

    rfd_collect u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .line_idle  (line_idle),
        .frame_done (frame_done),
        .frame      (frame)
    );

    rfd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_done  (frame_done),
        .frame       (frame),
        .cfg         (cfg_reg),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    rfd_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .cfg         (cfg_reg),
        .out_ready   (out_ready),
        .advance     (advance),
        .out_valid   (out_valid),
        .result      (result)
    );

    assign stick_0       = $signed(result.ch[0]);
    assign stick_1       = $signed(result.ch[1]);
    assign stick_2       = $signed(result.ch[2]);
    assign stick_3       = $signed(result.ch[3]);
    assign aux_channel   = $signed(result.aux);
    assign switches      = result.sw;
    assign mouse_x       = $signed(result.mouse_x);
    assign mouse_y       = $signed(result.mouse_y);
    assign mouse_z       = $signed(result.mouse_z);
    assign mouse_buttons = result.buttons;
    assign key_bits      = result.keys;
    assign data_error    = result.err;

    // a stalled request means both result stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("input stalled while result path has room");

    // a new result only comes from a held decode stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stage_valid))
    else $error("result appeared without a decoded frame");

    // an error frame carries zeroed aux, mouse_x and key bits and both switches forced down
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_error) |->
            (aux_channel == 16'sd0 && mouse_x == 16'sd0 && key_bits == 16'd0
             && switches == {cfg_reg.switch_down_code, cfg_reg.switch_down_code}))
    else $error("error frame with nonzero payload");

endmodule

`default_nettype wire
